// ----- src/teq_pkg.sv -----
`timescale 1ns / 1ps
package teq_pkg;

    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int FIFO_DEPTH  = 2;
    localparam logic [19:0] MIN_DELAY_RESET = 20'd100;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic {
        ACT_ADD  = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [47:0] now;
        logic [47:0] deadline;
        logic [31:0] period;
        logic [7:0]  timer_id;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  fired_id;
        logic        fired;
        logic        earliest_changed;
        logic        dropped;
        logic        queue_empty;
        logic [47:0] next_delay;
        logic        last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_REARM,
        ST_FINAL,
        ST_EMIT
    } exec_state_t;

    // true if (da,ia,sa) sorts before (db,ib,sb)
    function automatic logic sorts_before(
        input logic [47:0] da, input logic [7:0] ia, input logic [SLOT_W-1:0] sa,
        input logic [47:0] db, input logic [7:0] ib, input logic [SLOT_W-1:0] sb);
        logic r;
        if (da != db)
            r = da < db;
        else if (ia != ib)
            r = ia < ib;
        else
            r = sa < sb;
        return r;
    endfunction

endpackage

// ----- src/teq_front.sv -----
`timescale 1ns / 1ps
// Input stage: two-entry command queue in front of the executor.
module teq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  teq_pkg::cmd_t in_cmd,
    output logic          q_valid,
    input  logic          q_ready,
    output teq_pkg::cmd_t q_cmd
);

    teq_pkg::cmd_t mem_reg [teq_pkg::FIFO_DEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push, pop;

    assign in_ready = count_reg != 2'd2;
    assign q_valid  = count_reg != 2'd0;
    assign q_cmd    = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

// ----- src/teq_exec.sv -----
`timescale 1ns / 1ps
// Executor: slot store, sequential earliest search, pop/re-arm, result output.
module teq_exec (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [19:0]   min_delay,
    input  logic          q_valid,
    output logic          q_ready,
    input  teq_pkg::cmd_t q_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output teq_pkg::res_t out_res,
    output logic          busy
);

    localparam int SW = teq_pkg::SLOT_W;
    localparam int CW = teq_pkg::CNT_W;

    logic [47:0] dl_reg   [teq_pkg::CAPACITY];
    logic [31:0] per_reg  [teq_pkg::CAPACITY];
    logic [7:0]  id_reg   [teq_pkg::CAPACITY];
    logic [teq_pkg::CAPACITY-1:0] valid_reg;
    logic [teq_pkg::CAPACITY-1:0] popped_reg;

    teq_pkg::exec_state_t state_reg, state_next;
    teq_pkg::cmd_t        cmd_reg;
    logic [SW-1:0]        scan_reg;
    logic                 best_ok_reg;
    logic [SW-1:0]        best_reg;
    logic [CW-1:0]        pop_cnt_reg;
    logic [CW-1:0]        emit_reg;
    logic [7:0]           pop_ids_reg [teq_pkg::MAX_RESULTS];
    logic                 changed_reg, dropped_reg;
    logic                 empty_reg;
    logic [47:0]          delay_reg;
    logic                 phase_reg; // tick: 0 = popping, 1 = final search
    teq_pkg::res_t        out_reg;
    logic                 out_valid_reg, out_valid_next;

    logic [teq_pkg::CAPACITY-1:0] free_vec;
    logic [SW-1:0] free_idx;
    logic          full;
    logic          cand_better;
    logic          pop_due;
    logic [47:0]   diff, dly;
    logic [48:0]   rearm_sum;
    logic          out_free;

    always_comb
    begin
        free_vec = ~valid_reg;
        free_idx = '0;
        for (int i = teq_pkg::CAPACITY - 1; i >= 0; i--)
            if (free_vec[i])
                free_idx = SW'(i);
    end
    assign full = &valid_reg;

    assign cand_better = valid_reg[scan_reg] && (!best_ok_reg ||
        teq_pkg::sorts_before(dl_reg[scan_reg], id_reg[scan_reg], scan_reg,
                              dl_reg[best_reg], id_reg[best_reg], best_reg));

    assign pop_due = best_ok_reg && dl_reg[best_reg] <= cmd_reg.now &&
                     pop_cnt_reg != CW'(teq_pkg::MAX_RESULTS);

    assign diff = (dl_reg[best_reg] > cmd_reg.now) ? dl_reg[best_reg] - cmd_reg.now : '0;
    assign dly  = (diff < {28'd0, min_delay}) ? {28'd0, min_delay} : diff;
    assign rearm_sum = {1'b0, cmd_reg.now} + {17'd0, per_reg[best_reg]};
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid_next = (state_reg == teq_pkg::ST_EMIT && out_free) ||
                            (out_valid_reg && !out_ready);

    assign q_ready   = state_reg == teq_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign busy      = state_reg != teq_pkg::ST_IDLE || out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            teq_pkg::ST_IDLE:
                if (q_valid)
                    state_next = teq_pkg::ST_SCAN;
            teq_pkg::ST_SCAN:
                if (scan_reg == SW'(teq_pkg::CAPACITY - 1))
                    state_next = teq_pkg::ST_POP;
            teq_pkg::ST_POP:
                // add: insert after first scan; tick: pop earliest if due, else go to re-arm
                if (cmd_reg.action == teq_pkg::ACT_ADD)
                    state_next = phase_reg ? teq_pkg::ST_SCAN : teq_pkg::ST_FINAL;
                else if (phase_reg)
                    state_next = teq_pkg::ST_FINAL;
                else if (pop_due)
                    state_next = teq_pkg::ST_SCAN;
                else
                    state_next = teq_pkg::ST_REARM;
            teq_pkg::ST_REARM:
                if (best_reg == SW'(teq_pkg::CAPACITY - 1))
                    state_next = teq_pkg::ST_SCAN;
            teq_pkg::ST_FINAL:
                state_next = teq_pkg::ST_EMIT;
            teq_pkg::ST_EMIT:
                if (out_free && (emit_reg + CW'(1) >= pop_cnt_reg))
                    state_next = teq_pkg::ST_IDLE;
            default:
                state_next = teq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= teq_pkg::ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            case (state_reg)
                teq_pkg::ST_IDLE:
                    if (q_valid)
                    begin
                        cmd_reg     <= q_cmd;
                        scan_reg    <= '0;
                        best_ok_reg <= 1'b0;
                        best_reg    <= '0;
                        pop_cnt_reg <= '0;
                        emit_reg    <= '0;
                        popped_reg  <= '0;
                        changed_reg <= 1'b0;
                        phase_reg   <= q_cmd.action == teq_pkg::ACT_ADD;
                        dropped_reg <= (q_cmd.action == teq_pkg::ACT_ADD) && full;
                    end
                teq_pkg::ST_SCAN:
                begin
                    if (cand_better)
                    begin
                        best_ok_reg <= 1'b1;
                        best_reg    <= scan_reg;
                    end
                    scan_reg <= scan_reg + SW'(1);
                end
                teq_pkg::ST_POP:
                begin
                    if (cmd_reg.action == teq_pkg::ACT_ADD && phase_reg)
                    begin
                        if (!dropped_reg)
                        begin
                            changed_reg <= !best_ok_reg ||
                                           cmd_reg.deadline < dl_reg[best_reg];
                            dl_reg[free_idx]  <= cmd_reg.deadline;
                            per_reg[free_idx] <= cmd_reg.period;
                            id_reg[free_idx]  <= cmd_reg.timer_id;
                            valid_reg[free_idx] <= 1'b1;
                        end
                        phase_reg   <= 1'b0;
                        scan_reg    <= '0;
                        best_ok_reg <= 1'b0;
                    end
                    else if (cmd_reg.action == teq_pkg::ACT_TICK && !phase_reg && pop_due)
                    begin
                        valid_reg[best_reg]  <= 1'b0;
                        popped_reg[best_reg] <= 1'b1;
                        pop_ids_reg[pop_cnt_reg[SW-1:0]] <= id_reg[best_reg];
                        pop_cnt_reg <= pop_cnt_reg + CW'(1);
                        scan_reg    <= '0;
                        best_ok_reg <= 1'b0;
                    end
                    else if (cmd_reg.action == teq_pkg::ACT_TICK && !phase_reg)
                    begin
                        scan_reg <= '0;
                        best_reg <= '0;
                    end
                end
                teq_pkg::ST_REARM:
                begin
                    // walk slots, re-arming popped periodic ones
                    if (popped_reg[best_reg] && per_reg[best_reg] != '0)
                    begin
                        dl_reg[best_reg]    <= rearm_sum[48] ? teq_pkg::TIME_MAX
                                                             : rearm_sum[47:0];
                        valid_reg[best_reg] <= 1'b1;
                    end
                    // wraps to slot 0 after the last one
                    best_reg <= best_reg + SW'(1);
                    if (best_reg == SW'(teq_pkg::CAPACITY - 1))
                    begin
                        phase_reg   <= 1'b1;
                        scan_reg    <= '0;
                        best_ok_reg <= 1'b0;
                    end
                end
                teq_pkg::ST_FINAL:
                begin
                    empty_reg <= !best_ok_reg;
                    delay_reg <= best_ok_reg ? dly : '0;
                end
                teq_pkg::ST_EMIT:
                    if (out_free)
                    begin
                        out_reg.fired            <= pop_cnt_reg != '0;
                        out_reg.fired_id         <= (pop_cnt_reg != '0)
                                                    ? pop_ids_reg[emit_reg[SW-1:0]] : 8'd0;
                        out_reg.earliest_changed <= changed_reg;
                        out_reg.dropped          <= dropped_reg;
                        out_reg.queue_empty      <= empty_reg;
                        out_reg.next_delay       <= delay_reg;
                        out_reg.last             <= emit_reg + CW'(1) >= pop_cnt_reg;
                        emit_reg                 <= emit_reg + CW'(1);
                    end
                default: ;
            endcase
        end
    end

endmodule

// ----- src/timer_expiry_queue.sv -----
`timescale 1ns / 1ps
// Timer expiry queue: holds up to 16 timers ordered by deadline (ties by id, then
// slot). Commands enter a 2-word queue; the executor handles one at a time. Each
// earliest-timer search walks all 16 slots, one per cycle. An add searches, inserts
// (unless the store is full) and searches again before giving its word. A tick
// searches and pops each due timer in turn, walks all slots to re-arm the popped
// periodic ones, runs a final search, then gives one output word per cycle while out_ready is high.
// The min_delay register is written only while no command is pending.
module timer_expiry_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [47:0] now,
    input  logic [47:0] deadline,
    input  logic [31:0] period,
    input  logic [7:0]  timer_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  fired_id,
    output logic        fired,
    output logic        earliest_changed,
    output logic        dropped,
    output logic        queue_empty,
    output logic [47:0] next_delay,
    output logic        last
);

    teq_pkg::cmd_t in_cmd, q_cmd;
    teq_pkg::res_t res;
    logic          q_valid, q_ready, busy;
    logic [19:0]   min_delay_reg;

    assign cfg_ready = !busy && !q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_delay_reg <= teq_pkg::MIN_DELAY_RESET;
        else if (cfg_valid && cfg_ready)
            min_delay_reg <= cfg_data;
    end

    always_comb
    begin
        in_cmd.action   = teq_pkg::action_t'(action);
        in_cmd.now      = now;
        in_cmd.deadline = deadline;
        in_cmd.period   = period;
        in_cmd.timer_id = timer_id;
    end

    teq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    teq_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .min_delay (min_delay_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res),
        .busy      (busy)
    );

    assign fired_id         = res.fired_id;
    assign fired            = res.fired;
    assign earliest_changed = res.earliest_changed;
    assign dropped          = res.dropped;
    assign queue_empty      = res.queue_empty;
    assign next_delay       = res.next_delay;
    assign last             = res.last;

`ifndef SYNTHESIS
    a_fired_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> fired_id == 8'd0)
        else $error("fired_id set without fired");
    a_add_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> !earliest_changed && !dropped)
        else $error("add flags on a fired word");
    a_empty_delay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && queue_empty |-> next_delay == 48'd0)
        else $error("delay nonzero on empty queue");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [19:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [47:0] now;
    logic [47:0] deadline;
    logic [31:0] period;
    logic [7:0]  timer_id;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  fired_id;
    logic        fired;
    logic        earliest_changed;
    logic        dropped;
    logic        queue_empty;
    logic [47:0] next_delay;
    logic        last;

    timer_expiry_queue dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .now(now), .deadline(deadline), .period(period),
        .timer_id(timer_id),
        .out_valid(out_valid), .out_ready(out_ready),
        .fired_id(fired_id), .fired(fired), .earliest_changed(earliest_changed),
        .dropped(dropped), .queue_empty(queue_empty), .next_delay(next_delay),
        .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // timer store model
    logic [47:0] m_deadline [teq_pkg::CAPACITY];
    logic [31:0] m_period [teq_pkg::CAPACITY];
    logic [7:0]  m_id [teq_pkg::CAPACITY];
    logic        m_valid [teq_pkg::CAPACITY];
    logic [19:0] m_min_delay;

    teq_pkg::cmd_t pending_cmds[$];
    teq_pkg::res_t expected_results[$];

    int  send_idle_pct;
    int  stall_pct;
    int  mismatches;
    bit  timed_out;
    longint cycles;

    // set at the rising edge when the current word was taken
    logic in_ready_seen;

    function automatic bit slot_first(int a, int b);
        if (m_deadline[a] != m_deadline[b])
            return m_deadline[a] < m_deadline[b];
        if (m_id[a] != m_id[b])
            return m_id[a] < m_id[b];
        return a < b;
    endfunction

    function automatic int earliest_timer();
        int best;
        best = -1;
        for (int i = 0; i < teq_pkg::CAPACITY; i++)
            if (m_valid[i] && (best < 0 || slot_first(i, best)))
                best = i;
        return best;
    endfunction

    function automatic logic [47:0] delay_until_next(logic [47:0] t);
        int e;
        logic [47:0] d;
        e = earliest_timer();
        if (e < 0)
            return 48'd0;
        d = (m_deadline[e] > t) ? m_deadline[e] - t : 48'd0;
        if (d < {28'd0, m_min_delay})
            d = {28'd0, m_min_delay};
        return d;
    endfunction

    task automatic predict_timer_step(input teq_pkg::cmd_t c);
        teq_pkg::res_t r;
        int popped[$];
        int e;
        int free_slot;
        logic [48:0] t;
        logic [47:0] dly;
        logic emp;
        r = '0;
        if (c.action == teq_pkg::ACT_ADD)
        begin
            e = earliest_timer();
            free_slot = -1;
            for (int i = 0; i < teq_pkg::CAPACITY; i++)
                if (!m_valid[i] && free_slot < 0)
                    free_slot = i;
            if (free_slot < 0)
                r.dropped = 1'b1;
            else
            begin
                r.earliest_changed = (e < 0) || (c.deadline < m_deadline[e]);
                m_deadline[free_slot] = c.deadline;
                m_period[free_slot] = c.period;
                m_id[free_slot] = c.timer_id;
                m_valid[free_slot] = 1'b1;
            end
            r.next_delay = delay_until_next(c.now);
            r.queue_empty = earliest_timer() < 0;
            r.last = 1'b1;
            expected_results.push_back(r);
        end
        else
        begin
            while (popped.size() < teq_pkg::MAX_RESULTS)
            begin
                e = earliest_timer();
                if (e < 0 || m_deadline[e] > c.now)
                    break;
                m_valid[e] = 1'b0;
                popped.push_back(e);
            end
            foreach (popped[k])
                if (m_period[popped[k]] != 0)
                begin
                    t = {1'b0, c.now} + {17'd0, m_period[popped[k]]};
                    m_deadline[popped[k]] = t[48] ? teq_pkg::TIME_MAX : t[47:0];
                    m_valid[popped[k]] = 1'b1;
                end
            dly = delay_until_next(c.now);
            emp = earliest_timer() < 0;
            if (popped.size() == 0)
            begin
                r.queue_empty = emp;
                r.next_delay = dly;
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            else
                foreach (popped[k])
                begin
                    r = '0;
                    r.fired_id = m_id[popped[k]];
                    r.fired = 1'b1;
                    r.queue_empty = emp;
                    r.next_delay = dly;
                    r.last = (k == popped.size() - 1);
                    expected_results.push_back(r);
                end
        end
    endtask

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
            action <= teq_pkg::ACT_ADD;
            now <= '0;
            deadline <= '0;
            period <= '0;
            timer_id <= '0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
            if (!in_valid || in_ready_seen)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    action <= pending_cmds[0].action;
                    now <= pending_cmds[0].now;
                    deadline <= pending_cmds[0].deadline;
                    period <= pending_cmds[0].period;
                    timer_id <= pending_cmds[0].timer_id;
                    void'(pending_cmds.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ready_seen <= 1'b0;
        else
        begin
            cycles++;
            in_ready_seen <= in_valid && in_ready;
            if (in_valid && in_ready)
                predict_timer_step(teq_pkg::cmd_t'{teq_pkg::action_t'(action), now,
                                                   deadline, period, timer_id});
            if (out_valid && out_ready)
            begin
                teq_pkg::res_t got;
                teq_pkg::res_t want;
                got = '{fired_id, fired, earliest_changed, dropped, queue_empty,
                        next_delay, last};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (cycles > 64'd3000000)
                timed_out = 1'b1;
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic teq_pkg::cmd_t add_cmd(logic [47:0] t, logic [47:0] dl,
                                              logic [31:0] p, logic [7:0] id);
        return '{teq_pkg::ACT_ADD, t, dl, p, id};
    endfunction

    function automatic teq_pkg::cmd_t tick_cmd(logic [47:0] t);
        return '{teq_pkg::ACT_TICK, t, rand48(), 32'($urandom), 8'($urandom)};
    endfunction

    task automatic wait_drained();
        while ((pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
               && !timed_out)
            @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    task automatic write_min_delay(logic [19:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        m_min_delay = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed: adds near a moving clock, ticks that cross deadlines
    task automatic random_phase(int n, logic [47:0] base);
        logic [47:0] clock_now;
        int sel;
        clock_now = base;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 55)
                pending_cmds.push_back(add_cmd(clock_now,
                    clock_now + $urandom_range(2000),
                    ($urandom_range(2) == 0) ? 32'd0 : $urandom_range(1500),
                    8'($urandom_range(7))));
            else if (sel < 90)
            begin
                clock_now = clock_now + $urandom_range(1200);
                pending_cmds.push_back(tick_cmd(clock_now));
            end
            else if (sel < 95)
                pending_cmds.push_back(add_cmd(rand48(), rand48(), $urandom,
                                               8'($urandom)));
            else
                pending_cmds.push_back(tick_cmd(rand48()));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        timed_out = 1'b0;
        cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        m_min_delay = teq_pkg::MIN_DELAY_RESET;
        for (int i = 0; i < teq_pkg::CAPACITY; i++)
            m_valid[i] = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty tick, ties, full store, overflow re-arm, field extremes
        pending_cmds.push_back(tick_cmd(48'd0));
        pending_cmds.push_back(add_cmd(48'd0, 48'd500, 32'd0, 8'd9));
        pending_cmds.push_back(add_cmd(48'd0, 48'd500, 32'd0, 8'd3));
        pending_cmds.push_back(add_cmd(48'd0, 48'd500, 32'd0, 8'd3));
        pending_cmds.push_back(add_cmd(48'd0, 48'd600, 32'd0, 8'd3));
        pending_cmds.push_back(add_cmd(48'd0, 48'd10, 32'hFFFF_FFFF, 8'hFF));
        pending_cmds.push_back(add_cmd(48'd0, teq_pkg::TIME_MAX - 48'd5, 32'hFFFF_FFFF,
                                       8'd0));
        for (int i = 0; i < 11; i++)
            pending_cmds.push_back(add_cmd(48'd0, 48'd50 + 48'(i), 32'd7, i[7:0]));
        pending_cmds.push_back(tick_cmd(48'd1000));
        pending_cmds.push_back(tick_cmd(48'd1000));
        pending_cmds.push_back(tick_cmd(teq_pkg::TIME_MAX));
        pending_cmds.push_back(tick_cmd(teq_pkg::TIME_MAX));
        wait_drained();

        write_min_delay(20'd0);
        send_idle_pct = 86;
        random_phase(60, 48'd0);
        wait_drained();
        // hold the sender until everything has drained, then go on
        write_min_delay(20'hFFFFF);
        send_idle_pct = 0;
        stall_pct = 86;
        random_phase(60, 48'd100000);
        wait_drained();
        write_min_delay(20'd37);
        send_idle_pct = 36;
        stall_pct = 36;
        random_phase(60, teq_pkg::TIME_MAX - 48'd50000);
        wait_drained();
        write_min_delay(teq_pkg::MIN_DELAY_RESET);
        send_idle_pct = 0;
        stall_pct = 0;
        random_phase(70, 48'd5000000);
        wait_drained();

        if (!timed_out && mismatches == 0 && expected_results.size() == 0)
            $display("** timer_expiry_queue: PASSED **");
        else
            $display("** timer_expiry_queue: FAILED **");
        $finish;
    end

    initial
    begin
        wait (timed_out);
        $display("** timer_expiry_queue: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
src/teq_pkg.sv
src/teq_front.sv
src/teq_exec.sv
src/timer_expiry_queue.sv
tb/tb.sv
